>>> rtl/qru_pkg.sv
// ----------------------------------------------------------------------------
// qru_pkg
// Shared types, constants and arithmetic helpers for the quaternion unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qru_pkg;

  // Component format: signed fixed point, FB fraction bits
  localparam int CW = 16;
  localparam int FB = 14;
  // Product width: (CW+1) x (CW+1) signed operands
  localparam int PW = 2 * CW + 2;
  // Sum width: headroom for a handful of rounded products
  localparam int SW = PW + 3;
  // Lanes of the first and second product layers
  localparam int L1_LANES = 16;
  localparam int L2_LANES = 9;
  localparam int MID_N    = 9;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [CW:0]   ncomp_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [SW-1:0] sum_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_ROT  = 2'd1,
    OP_IROT = 2'd2,
    OP_CONJ = 2'd3
  } op_t;

  localparam sum_t CMAX = sum_t'((longint'(1) <<< (CW - 1)) - longint'(1));
  localparam sum_t CMIN = sum_t'(-(longint'(1) <<< (CW - 1)));
  localparam sum_t FONE = sum_t'(longint'(1) <<< FB);
  localparam prod_t HALF_ONE = prod_t'(longint'(1) <<< (FB - 1));
  localparam prod_t HALF_DBL = prod_t'(longint'(1) <<< (FB - 2));

  // Input transaction
  typedef struct packed {
    op_t   op;
    comp_t ax;
    comp_t ay;
    comp_t az;
    comp_t aw;
    comp_t bx;
    comp_t by;
    comp_t bz;
    comp_t bw;
  } in_t;

  // Between first and second half of the pipe
  typedef struct packed {
    op_t               op;
    comp_t [MID_N-1:0] mid;  // matrix entries (rotate) or cross term (inverse)
    comp_t [3:0]       d;    // finished result for multiply / conjugate
    comp_t             bx;
    comp_t             by;
    comp_t             bz;
    comp_t             aw;
    ncomp_t            qx;
    ncomp_t            qy;
    ncomp_t            qz;
    logic              sat;
  } mid_t;

  typedef struct packed {
    logic  sat;
    comp_t val;
  } clamp_t;

  // Sign-extend a component by one bit
  function automatic ncomp_t ext_c(comp_t c);
    return {c[CW-1], c};
  endfunction

  // Negate a component; one extra bit so the most negative value fits
  function automatic ncomp_t neg_c(comp_t c);
    return -ext_c(c);
  endfunction

  // Round half up to FB fraction bits; dbl folds a factor of two in
  function automatic prod_t round_prod(prod_t p, logic dbl);
    prod_t r;
    if (dbl) begin
      r = (p + HALF_DBL) >>> (FB - 1);
    end else begin
      r = (p + HALF_ONE) >>> FB;
    end
    return r;
  endfunction

  function automatic sum_t widen(prod_t p);
    return sum_t'(p);
  endfunction

  function automatic sum_t widen_c(comp_t c);
    return sum_t'(c);
  endfunction

  function automatic clamp_t clamp_c(sum_t v);
    clamp_t r;
    if (v > CMAX) begin
      r.sat = 1'b1;
      r.val = comp_t'(CMAX);
    end else if (v < CMIN) begin
      r.sat = 1'b1;
      r.val = comp_t'(CMIN);
    end else begin
      r.sat = 1'b0;
      r.val = v[CW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qru_front.sv
// ----------------------------------------------------------------------------
// qru_front
// First product layer: quaternion products, rotation matrix entries or the
// cross term, rounded, summed and clamped. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qru_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire qru_pkg::in_t  in_data,
  output logic               out_valid,
  output qru_pkg::mid_t      out_data
);
  import qru_pkg::*;

  ncomp_t opa [L1_LANES];
  ncomp_t opb [L1_LANES];
  prod_t  prod [L1_LANES];
  in_t    s2;
  logic   s2_valid;

  prod_t  r  [L1_LANES];
  sum_t   sv [MID_N];
  sum_t   dv [4];
  clamp_t cm [MID_N];
  clamp_t cd [4];
  mid_t   mid_next;

  // Operand selection for the shared multiplier bank
  always_comb begin
    for (int i = 0; i < L1_LANES; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    unique case (in_data.op)
      OP_MUL: begin
        opa[0]  = ext_c(in_data.bx); opb[0]  = ext_c(in_data.aw);
        opa[1]  = ext_c(in_data.ax); opb[1]  = ext_c(in_data.bw);
        opa[2]  = ext_c(in_data.by); opb[2]  = ext_c(in_data.az);
        opa[3]  = ext_c(in_data.bz); opb[3]  = ext_c(in_data.ay);
        opa[4]  = ext_c(in_data.by); opb[4]  = ext_c(in_data.aw);
        opa[5]  = ext_c(in_data.ay); opb[5]  = ext_c(in_data.bw);
        opa[6]  = ext_c(in_data.bz); opb[6]  = ext_c(in_data.ax);
        opa[7]  = ext_c(in_data.bx); opb[7]  = ext_c(in_data.az);
        opa[8]  = ext_c(in_data.bz); opb[8]  = ext_c(in_data.aw);
        opa[9]  = ext_c(in_data.az); opb[9]  = ext_c(in_data.bw);
        opa[10] = ext_c(in_data.bx); opb[10] = ext_c(in_data.ay);
        opa[11] = ext_c(in_data.by); opb[11] = ext_c(in_data.ax);
        opa[12] = ext_c(in_data.bw); opb[12] = ext_c(in_data.aw);
        opa[13] = ext_c(in_data.bx); opb[13] = ext_c(in_data.ax);
        opa[14] = ext_c(in_data.by); opb[14] = ext_c(in_data.ay);
        opa[15] = ext_c(in_data.bz); opb[15] = ext_c(in_data.az);
      end
      OP_ROT: begin
        // wx wy wz xx xy xz yy yz zz
        opa[0] = ext_c(in_data.aw); opb[0] = ext_c(in_data.ax);
        opa[1] = ext_c(in_data.aw); opb[1] = ext_c(in_data.ay);
        opa[2] = ext_c(in_data.aw); opb[2] = ext_c(in_data.az);
        opa[3] = ext_c(in_data.ax); opb[3] = ext_c(in_data.ax);
        opa[4] = ext_c(in_data.ax); opb[4] = ext_c(in_data.ay);
        opa[5] = ext_c(in_data.ax); opb[5] = ext_c(in_data.az);
        opa[6] = ext_c(in_data.ay); opb[6] = ext_c(in_data.ay);
        opa[7] = ext_c(in_data.ay); opb[7] = ext_c(in_data.az);
        opa[8] = ext_c(in_data.az); opb[8] = ext_c(in_data.az);
      end
      OP_IROT: begin
        // q = -a.xyz; pairs of q x v
        opa[0] = neg_c(in_data.ay); opb[0] = ext_c(in_data.bz);
        opa[1] = neg_c(in_data.az); opb[1] = ext_c(in_data.by);
        opa[2] = neg_c(in_data.az); opb[2] = ext_c(in_data.bx);
        opa[3] = neg_c(in_data.ax); opb[3] = ext_c(in_data.bz);
        opa[4] = neg_c(in_data.ax); opb[4] = ext_c(in_data.by);
        opa[5] = neg_c(in_data.ay); opb[5] = ext_c(in_data.bx);
      end
      default: begin
      end
    endcase
  end

  // Stage 2: raw products
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
    end
    for (int i = 0; i < L1_LANES; i++) begin
      prod[i] <= prod_t'(opa[i]) * prod_t'(opb[i]);
    end
    s2 <= in_data;
  end

  // Rounding, sums and clamps
  always_comb begin
    for (int i = 0; i < L1_LANES; i++) begin
      r[i] = round_prod(prod[i], s2.op != OP_MUL);
    end
    for (int i = 0; i < MID_N; i++) begin
      sv[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      dv[i] = '0;
    end
    unique case (s2.op)
      OP_MUL: begin
        dv[0] = widen(r[0]) + widen(r[1]) + widen(r[2]) - widen(r[3]);
        dv[1] = widen(r[4]) + widen(r[5]) + widen(r[6]) - widen(r[7]);
        dv[2] = widen(r[8]) + widen(r[9]) + widen(r[10]) - widen(r[11]);
        dv[3] = widen(r[12]) - (widen(r[13]) + widen(r[14]) + widen(r[15]));
      end
      OP_ROT: begin
        sv[0] = FONE - widen(r[6]) - widen(r[8]);
        sv[1] = widen(r[4]) - widen(r[2]);
        sv[2] = widen(r[5]) + widen(r[1]);
        sv[3] = widen(r[4]) + widen(r[2]);
        sv[4] = FONE - widen(r[3]) - widen(r[8]);
        sv[5] = widen(r[7]) - widen(r[0]);
        sv[6] = widen(r[5]) - widen(r[1]);
        sv[7] = widen(r[7]) + widen(r[0]);
        sv[8] = FONE - widen(r[3]) - widen(r[6]);
      end
      OP_IROT: begin
        sv[0] = widen(r[0]) - widen(r[1]);
        sv[1] = widen(r[2]) - widen(r[3]);
        sv[2] = widen(r[4]) - widen(r[5]);
      end
      default: begin
        dv[0] = -widen_c(s2.ax);
        dv[1] = -widen_c(s2.ay);
        dv[2] = -widen_c(s2.az);
        dv[3] = widen_c(s2.aw);
      end
    endcase

    mid_next.op  = s2.op;
    mid_next.bx  = s2.bx;
    mid_next.by  = s2.by;
    mid_next.bz  = s2.bz;
    mid_next.aw  = s2.aw;
    mid_next.qx  = neg_c(s2.ax);
    mid_next.qy  = neg_c(s2.ay);
    mid_next.qz  = neg_c(s2.az);
    mid_next.sat = 1'b0;
    for (int i = 0; i < MID_N; i++) begin
      cm[i] = clamp_c(sv[i]);
      mid_next.mid[i] = cm[i].val;
      mid_next.sat = mid_next.sat | cm[i].sat;
    end
    for (int i = 0; i < 4; i++) begin
      cd[i] = clamp_c(dv[i]);
      mid_next.d[i] = cd[i].val;
      mid_next.sat = mid_next.sat | cd[i].sat;
    end
  end

  // Stage 3 register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
    out_data <= mid_next;
  end

endmodule

`default_nettype wire

>>> rtl/qru_back.sv
// ----------------------------------------------------------------------------
// qru_back
// Second product layer for the vector rotations: matrix times vector or the
// cross-product update, then the final clamp. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module qru_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire qru_pkg::mid_t in_data,
  output logic               out_valid,
  output qru_pkg::comp_t     out_x,
  output qru_pkg::comp_t     out_y,
  output qru_pkg::comp_t     out_z,
  output qru_pkg::comp_t     out_w,
  output logic               out_sat
);
  import qru_pkg::*;

  ncomp_t      opa [L2_LANES];
  ncomp_t      opb [L2_LANES];
  prod_t       prod [L2_LANES];
  logic        s4_valid;
  op_t         s4_op;
  comp_t       s4_b [3];
  comp_t [3:0] s4_d;
  logic        s4_sat;

  prod_t       r   [L2_LANES];
  sum_t        row [3];
  clamp_t      cr  [3];
  comp_t [3:0] res_next;
  logic        sat_next;
  logic        is_irot;

  // Operand selection for the second multiplier bank
  always_comb begin
    for (int i = 0; i < L2_LANES; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    unique case (in_data.op)
      OP_ROT: begin
        for (int k = 0; k < 3; k++) begin
          opa[3*k]   = ext_c(in_data.bx); opb[3*k]   = ext_c(in_data.mid[3*k]);
          opa[3*k+1] = ext_c(in_data.by); opb[3*k+1] = ext_c(in_data.mid[3*k+1]);
          opa[3*k+2] = ext_c(in_data.bz); opb[3*k+2] = ext_c(in_data.mid[3*k+2]);
        end
      end
      OP_IROT: begin
        // v' = v + w t + q x t, t held in mid[0..2]
        opa[0] = ext_c(in_data.aw); opb[0] = ext_c(in_data.mid[0]);
        opa[1] = in_data.qy;        opb[1] = ext_c(in_data.mid[2]);
        opa[2] = in_data.qz;        opb[2] = ext_c(in_data.mid[1]);
        opa[3] = ext_c(in_data.aw); opb[3] = ext_c(in_data.mid[1]);
        opa[4] = in_data.qz;        opb[4] = ext_c(in_data.mid[0]);
        opa[5] = in_data.qx;        opb[5] = ext_c(in_data.mid[2]);
        opa[6] = ext_c(in_data.aw); opb[6] = ext_c(in_data.mid[2]);
        opa[7] = in_data.qx;        opb[7] = ext_c(in_data.mid[1]);
        opa[8] = in_data.qy;        opb[8] = ext_c(in_data.mid[0]);
      end
      default: begin
      end
    endcase
  end

  // Stage 4: raw products
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= in_valid;
    end
    for (int i = 0; i < L2_LANES; i++) begin
      prod[i] <= prod_t'(opa[i]) * prod_t'(opb[i]);
    end
    s4_op   <= in_data.op;
    s4_b[0] <= in_data.bx;
    s4_b[1] <= in_data.by;
    s4_b[2] <= in_data.bz;
    s4_d    <= in_data.d;
    s4_sat  <= in_data.sat;
  end

  // Rounding, row sums and final clamp
  always_comb begin
    is_irot  = (s4_op == OP_IROT);
    sat_next = s4_sat;
    for (int i = 0; i < L2_LANES; i++) begin
      r[i] = round_prod(prod[i], 1'b0);
    end
    for (int k = 0; k < 3; k++) begin
      if (is_irot) begin
        row[k] = widen_c(s4_b[k]) + widen(r[3*k]) + widen(r[3*k+1]) - widen(r[3*k+2]);
      end else begin
        row[k] = widen(r[3*k]) + widen(r[3*k+1]) + widen(r[3*k+2]);
      end
      cr[k] = clamp_c(row[k]);
    end
    if (s4_op == OP_ROT || is_irot) begin
      res_next[0] = cr[0].val;
      res_next[1] = cr[1].val;
      res_next[2] = cr[2].val;
      res_next[3] = '0;
      sat_next    = s4_sat | cr[0].sat | cr[1].sat | cr[2].sat;
    end else begin
      res_next = s4_d;
    end
  end

  // Stage 5: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s4_valid;
    end
    out_x   <= res_next[0];
    out_y   <= res_next[1];
    out_z   <= res_next[2];
    out_w   <= res_next[3];
    out_sat <= sat_next;
  end

endmodule

`default_nettype wire

>>> rtl/quaternion_rotation_unit.sv
// ----------------------------------------------------------------------------
// quaternion_rotation_unit
// Fixed-point quaternion multiply, rotate, inverse rotate and conjugate.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op and the a_* / b_* operands with start high for
//   one cycle per transaction. busy stays low, so a new transaction may be
//   issued in every cycle.
//   Result channel: done is high for exactly one cycle with r_x..r_w and
//   saturated valid in that cycle. Results come back in issue order.
//   Pipeline: an input register, then two multiplier layers each split into
//   a product stage and a round/sum/clamp stage. Throughput: one transaction
//   per cycle, set by the fully pipelined multiplier banks (16 then 9 lanes).
//   Reset (rst, synchronous) clears every valid bit in the pipe; transactions
//   in flight are dropped. The receiver cannot stall: it must take done.
//   All values are signed Q2.14; results saturate and flag it.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rotation_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      op,
  input  wire qru_pkg::comp_t  a_x,
  input  wire qru_pkg::comp_t  a_y,
  input  wire qru_pkg::comp_t  a_z,
  input  wire qru_pkg::comp_t  a_w,
  input  wire qru_pkg::comp_t  b_x,
  input  wire qru_pkg::comp_t  b_y,
  input  wire qru_pkg::comp_t  b_z,
  input  wire qru_pkg::comp_t  b_w,
  output logic                 done,
  output qru_pkg::comp_t       r_x,
  output qru_pkg::comp_t       r_y,
  output qru_pkg::comp_t       r_z,
  output qru_pkg::comp_t       r_w,
  output logic                 saturated
);
  import qru_pkg::*;

  logic s1_valid;
  in_t  s1;
  logic mid_valid;
  mid_t mid;

  // Fully pipelined: never backs off the issuer
  assign busy = 1'b0;

  // Stage 1: input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start & ~busy;
    end
    s1.op <= op_t'(op);
    s1.ax <= a_x;
    s1.ay <= a_y;
    s1.az <= a_z;
    s1.aw <= a_w;
    s1.bx <= b_x;
    s1.by <= b_y;
    s1.bz <= b_z;
    s1.bw <= b_w;
  end

  qru_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_data   (s1),
    .out_valid (mid_valid),
    .out_data  (mid)
  );

  qru_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_data   (mid),
    .out_valid (done),
    .out_x     (r_x),
    .out_y     (r_y),
    .out_z     (r_z),
    .out_w     (r_w),
    .out_sat   (saturated)
  );

endmodule

`default_nettype wire
